FILE: hdl/vmbr_pkg.sv
// Shared types and constants of the virtio-mmio block register file.
package vmbr_pkg;

  // Request kinds, equal to the func field of an input request
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Register codes produced by the front decoder
  localparam logic [4:0] REG_NONE          = 5'd0;
  localparam logic [4:0] REG_MAGIC         = 5'd1;
  localparam logic [4:0] REG_VERSION       = 5'd2;
  localparam logic [4:0] REG_DEVICE_ID     = 5'd3;
  localparam logic [4:0] REG_VENDOR        = 5'd4;
  localparam logic [4:0] REG_DEV_FEAT      = 5'd5;
  localparam logic [4:0] REG_DEV_FEAT_SEL  = 5'd6;
  localparam logic [4:0] REG_QUEUE_SEL     = 5'd7;
  localparam logic [4:0] REG_QUEUE_NUM_MAX = 5'd8;
  localparam logic [4:0] REG_QUEUE_NUM     = 5'd9;
  localparam logic [4:0] REG_QUEUE_READY   = 5'd10;
  localparam logic [4:0] REG_QUEUE_NOTIFY  = 5'd11;
  localparam logic [4:0] REG_IRQ_STATUS    = 5'd12;
  localparam logic [4:0] REG_IRQ_ACK       = 5'd13;
  localparam logic [4:0] REG_STATUS        = 5'd14;
  localparam logic [4:0] REG_DESC_LO       = 5'd15;
  localparam logic [4:0] REG_DESC_HI       = 5'd16;
  localparam logic [4:0] REG_AVAIL_LO      = 5'd17;
  localparam logic [4:0] REG_AVAIL_HI      = 5'd18;
  localparam logic [4:0] REG_USED_LO       = 5'd19;
  localparam logic [4:0] REG_USED_HI       = 5'd20;
  localparam logic [4:0] REG_CONFIG        = 5'd21;

  // Configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_WPROT    = 1'b1;

  // Fixed identity and config space values
  localparam logic [31:0] MAGIC_VALUE       = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE     = 32'd2;
  localparam logic [31:0] DEVICE_ID         = 32'd2;
  localparam logic [31:0] VENDOR_VALUE      = 32'h554d_4551;
  localparam logic [31:0] QUEUE_SIZE_MAX    = 32'd256;
  localparam logic [31:0] SEG_MAX_VALUE     = 32'd128;
  localparam logic [31:0] SECTOR_SIZE_VALUE = 32'd512;

  // Config space bytes from this index on all read zero
  localparam logic [4:0] CFG_BYTES_USED = 5'd24;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
    logic [3:0]  access_bytes;
  } vmbr_in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        notify_pulse;
    logic        irq_pending;
    logic        q0_ready;
    logic [15:0] q0_size;
    logic [63:0] q0_desc_base;
    logic [63:0] q0_avail_base;
    logic [63:0] q0_used_base;
  } vmbr_out_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  reg_code;
    logic [31:0] data;
    logic [4:0]  cfg_base;
    logic [3:0]  cfg_len;
  } vmbr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vmbr_fifo_stat_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [47:0] wdata;
  } vmbr_cfg_wr_t;

endpackage

FILE: hdl/virtio_mmio_block_registers.sv
// Top level of the virtio-mmio version 2 block device register file.
// A request is first written into the two-entry request queue, then executed from
//   the queue head and loaded into the output register, from which it can be taken.
// Throughput: one request per cycle while out_stall is low and the output register drains.
// in_stall rises only when the two-entry request queue is full.
// Reset: synchronous active-low rst_n clears all device state, config and queues.
module virtio_mmio_block_registers #(
  parameter int QUEUE_COUNT = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  vmbr_pkg::vmbr_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output vmbr_pkg::vmbr_out_t out_data,
  // configuration writes: index 0 capacity, index 1 write protect
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [47:0]         cfg_wdata
);
  import vmbr_pkg::*;

  vmbr_cmd_t       push_cmd;
  vmbr_cmd_t       head_cmd;
  vmbr_fifo_stat_t fifo_stat;
  vmbr_cfg_wr_t    cfg_wr;
  logic            push;
  logic            pop;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.wdata = cfg_wdata;

  // Front: offset decode, config byte range clamp
  vmbr_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_stat (fifo_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decouples decode from execution so each side stalls on its own
  vmbr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .stat     (fifo_stat)
  );

  // Back: register state, read mux and the result register
  vmbr_back #(
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .fifo_stat (fifo_stat),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/vmbr_front.sv
// Front end: accepts requests and decodes the register offset.
module vmbr_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  vmbr_pkg::vmbr_in_t        in_data,
  input  vmbr_pkg::vmbr_fifo_stat_t fifo_stat,
  output logic                      push,
  output vmbr_pkg::vmbr_cmd_t       cmd
);
  import vmbr_pkg::*;

  localparam logic [11:0] OFF_MAGIC       = 12'h000;
  localparam logic [11:0] OFF_VERSION     = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID   = 12'h008;
  localparam logic [11:0] OFF_VENDOR      = 12'h00C;
  localparam logic [11:0] OFF_DEV_FEAT    = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SL = 12'h014;
  localparam logic [11:0] OFF_QUEUE_SEL   = 12'h030;
  localparam logic [11:0] OFF_QUEUE_MAX   = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM   = 12'h038;
  localparam logic [11:0] OFF_QUEUE_READY = 12'h044;
  localparam logic [11:0] OFF_NOTIFY      = 12'h050;
  localparam logic [11:0] OFF_IRQ_STATUS  = 12'h060;
  localparam logic [11:0] OFF_IRQ_ACK     = 12'h064;
  localparam logic [11:0] OFF_STATUS      = 12'h070;
  localparam logic [11:0] OFF_DESC_LO     = 12'h080;
  localparam logic [11:0] OFF_DESC_HI     = 12'h084;
  localparam logic [11:0] OFF_AVAIL_LO    = 12'h090;
  localparam logic [11:0] OFF_AVAIL_HI    = 12'h094;
  localparam logic [11:0] OFF_USED_LO     = 12'h0A0;
  localparam logic [11:0] OFF_USED_HI     = 12'h0A4;
  localparam logic [11:0] OFF_CONFIG      = 12'h100;

  logic [4:0]  code;
  logic [11:0] cfg_off;

  assign in_stall = fifo_stat.full;
  assign push     = in_valid && !fifo_stat.full;

  // Driver feature words and config generation decode to no register:
  // nothing consumes the former and the latter reads zero.
  always_comb begin
    code = REG_NONE;
    if (in_data.reg_offset >= OFF_CONFIG) begin
      code = REG_CONFIG;
    end else begin
      unique case (in_data.reg_offset)
        OFF_MAGIC:       code = REG_MAGIC;
        OFF_VERSION:     code = REG_VERSION;
        OFF_DEVICE_ID:   code = REG_DEVICE_ID;
        OFF_VENDOR:      code = REG_VENDOR;
        OFF_DEV_FEAT:    code = REG_DEV_FEAT;
        OFF_DEV_FEAT_SL: code = REG_DEV_FEAT_SEL;
        OFF_QUEUE_SEL:   code = REG_QUEUE_SEL;
        OFF_QUEUE_MAX:   code = REG_QUEUE_NUM_MAX;
        OFF_QUEUE_NUM:   code = REG_QUEUE_NUM;
        OFF_QUEUE_READY: code = REG_QUEUE_READY;
        OFF_NOTIFY:      code = REG_QUEUE_NOTIFY;
        OFF_IRQ_STATUS:  code = REG_IRQ_STATUS;
        OFF_IRQ_ACK:     code = REG_IRQ_ACK;
        OFF_STATUS:      code = REG_STATUS;
        OFF_DESC_LO:     code = REG_DESC_LO;
        OFF_DESC_HI:     code = REG_DESC_HI;
        OFF_AVAIL_LO:    code = REG_AVAIL_LO;
        OFF_AVAIL_HI:    code = REG_AVAIL_HI;
        OFF_USED_LO:     code = REG_USED_LO;
        OFF_USED_HI:     code = REG_USED_HI;
        default:         code = REG_NONE;
      endcase
    end
  end

  assign cfg_off = in_data.reg_offset - OFF_CONFIG;

  always_comb begin
    cmd.kind     = in_data.func;
    cmd.reg_code = code;
    cmd.data     = in_data.write_data;
    // clamp the start byte: anything from byte 24 on reads zero
    cmd.cfg_base = (cfg_off < 12'(CFG_BYTES_USED)) ? cfg_off[4:0] : CFG_BYTES_USED;
    cmd.cfg_len  = (in_data.access_bytes > 4'd8) ? 4'd8 : in_data.access_bytes;
  end

endmodule

FILE: hdl/vmbr_cmd_fifo.sv
// Two-entry queue of decoded requests between front and back.
module vmbr_cmd_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  vmbr_pkg::vmbr_cmd_t       push_cmd,
  input  logic                      pop,
  output vmbr_pkg::vmbr_cmd_t       head,
  output vmbr_pkg::vmbr_fifo_stat_t stat
);
  import vmbr_pkg::*;

  vmbr_cmd_t  mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

FILE: hdl/vmbr_back.sv
// Back end: register state, request execution and the output register.
module vmbr_back #(
  parameter int QUEUE_COUNT = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vmbr_pkg::vmbr_cfg_wr_t    cfg_wr,
  input  vmbr_pkg::vmbr_fifo_stat_t fifo_stat,
  input  vmbr_pkg::vmbr_cmd_t       cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output vmbr_pkg::vmbr_out_t       out_data
);
  import vmbr_pkg::*;

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  logic [47:0]   capacity_r;
  logic          wprot_r;
  logic [31:0]   dev_page_r;
  logic [31:0]   dev_page_nxt;
  logic [QW-1:0] qsel_r;
  logic [QW-1:0] qsel_nxt;
  logic [15:0]   qsize_r     [QUEUE_COUNT];
  logic [15:0]   qsize_nxt   [QUEUE_COUNT];
  logic [31:0]   qready_r    [QUEUE_COUNT];
  logic [31:0]   qready_nxt  [QUEUE_COUNT];
  logic [63:0]   desc_r      [QUEUE_COUNT];
  logic [63:0]   desc_nxt    [QUEUE_COUNT];
  logic [63:0]   avail_r     [QUEUE_COUNT];
  logic [63:0]   avail_nxt   [QUEUE_COUNT];
  logic [63:0]   used_r      [QUEUE_COUNT];
  logic [63:0]   used_nxt    [QUEUE_COUNT];
  logic [31:0]   irq_r;
  logic [31:0]   irq_nxt;
  logic [31:0]   status_r;
  logic [31:0]   status_nxt;

  logic          load;
  logic          exec;
  logic          is_write;
  logic [63:0]   rd_data;
  logic [63:0]   cfg_data;
  logic          notify;
  logic          out_valid_r;
  vmbr_out_t     out_r;
  vmbr_out_t     out_nxt;

  // Output register takes a new result when empty or being drained
  assign load     = !out_valid_r || !out_stall;
  assign exec     = !fifo_stat.empty && load;
  assign pop      = exec;
  assign is_write = exec && (cmd.kind == OP_WRITE);

  function automatic logic [7:0] cfg_byte(input logic [4:0] idx, input logic [47:0] cap);
    logic [7:0] b;
    b = 8'd0;
    if (idx < 5'd6) begin
      b = cap[{idx[2:0], 3'b000} +: 8];
    end else if (idx >= 5'd12 && idx < 5'd16) begin
      b = SEG_MAX_VALUE[{idx[1:0], 3'b000} +: 8];
    end else if (idx >= 5'd20 && idx < 5'd24) begin
      b = SECTOR_SIZE_VALUE[{idx[1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Little-endian config space read, one byte lane per access byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cfg_data[8*i +: 8] = (4'(i) < cmd.cfg_len) ?
                           cfg_byte(cmd.cfg_base + 5'(i), capacity_r) : 8'd0;
    end
  end

  always_comb begin
    rd_data = 64'd0;
    if (cmd.kind == OP_READ) begin
      unique case (cmd.reg_code)
        REG_MAGIC:         rd_data = 64'(MAGIC_VALUE);
        REG_VERSION:       rd_data = 64'(VERSION_VALUE);
        REG_DEVICE_ID:     rd_data = 64'(DEVICE_ID);
        REG_VENDOR:        rd_data = 64'(VENDOR_VALUE);
        REG_DEV_FEAT: begin
          if (dev_page_r == 32'd0) begin
            rd_data = {57'd0, 1'b1, wprot_r, 5'd0};
          end else if (dev_page_r == 32'd1) begin
            rd_data = 64'd1;
          end
        end
        REG_QUEUE_NUM_MAX: rd_data = 64'(QUEUE_SIZE_MAX);
        REG_QUEUE_READY:   rd_data = 64'(qready_r[qsel_r]);
        REG_IRQ_STATUS:    rd_data = 64'(irq_r);
        REG_STATUS:        rd_data = 64'(status_r);
        REG_CONFIG:        rd_data = cfg_data;
        default:           rd_data = 64'd0;
      endcase
    end
  end

  always_comb begin
    dev_page_nxt = dev_page_r;
    qsel_nxt     = qsel_r;
    qsize_nxt    = qsize_r;
    qready_nxt   = qready_r;
    desc_nxt     = desc_r;
    avail_nxt    = avail_r;
    used_nxt     = used_r;
    irq_nxt      = irq_r;
    status_nxt   = status_r;
    notify       = 1'b0;
    if (exec && cmd.kind == OP_EVENT) begin
      irq_nxt = irq_r | 32'd1;
    end
    if (is_write) begin
      unique case (cmd.reg_code)
        REG_DEV_FEAT_SEL: dev_page_nxt = cmd.data;
        REG_QUEUE_SEL: begin
          if (cmd.data < 32'(QUEUE_COUNT)) begin
            qsel_nxt = cmd.data[QW-1:0];
          end
        end
        REG_QUEUE_NUM:    qsize_nxt[qsel_r] = cmd.data[15:0];
        REG_QUEUE_READY:  qready_nxt[qsel_r] = cmd.data;
        REG_QUEUE_NOTIFY: notify = 1'b1;
        REG_IRQ_ACK:      irq_nxt = irq_r & ~cmd.data;
        REG_STATUS: begin
          status_nxt = cmd.data;
          // status 0 is a device reset
          if (cmd.data == 32'd0) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
              qready_nxt[q] = 32'd0;
            end
            irq_nxt = 32'd0;
          end
        end
        REG_DESC_LO:      desc_nxt[qsel_r][31:0]   = cmd.data;
        REG_DESC_HI:      desc_nxt[qsel_r][63:32]  = cmd.data;
        REG_AVAIL_LO:     avail_nxt[qsel_r][31:0]  = cmd.data;
        REG_AVAIL_HI:     avail_nxt[qsel_r][63:32] = cmd.data;
        REG_USED_LO:      used_nxt[qsel_r][31:0]   = cmd.data;
        REG_USED_HI:      used_nxt[qsel_r][63:32]  = cmd.data;
        default:          notify = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_nxt.read_data     = rd_data;
    out_nxt.notify_pulse  = notify;
    out_nxt.irq_pending   = |irq_nxt;
    out_nxt.q0_ready      = |qready_nxt[0];
    out_nxt.q0_size       = qsize_nxt[0];
    out_nxt.q0_desc_base  = desc_nxt[0];
    out_nxt.q0_avail_base = avail_nxt[0];
    out_nxt.q0_used_base  = used_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 48'd0;
      wprot_r    <= 1'b0;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_CAPACITY: capacity_r <= cfg_wr.wdata;
        CFG_WPROT:    wprot_r    <= cfg_wr.wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_page_r <= 32'd0;
      qsel_r     <= '0;
      irq_r      <= 32'd0;
      status_r   <= 32'd0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        qsize_r[q]  <= 16'd0;
        qready_r[q] <= 32'd0;
        desc_r[q]   <= 64'd0;
        avail_r[q]  <= 64'd0;
        used_r[q]   <= 64'd0;
      end
    end else begin
      dev_page_r <= dev_page_nxt;
      qsel_r     <= qsel_nxt;
      irq_r      <= irq_nxt;
      status_r   <= status_nxt;
      qsize_r    <= qsize_nxt;
      qready_r   <= qready_nxt;
      desc_r     <= desc_nxt;
      avail_r    <= avail_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_exec_presents : assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed request did not reach the output register");

  a_irq_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !(cfg_wr.we)) |=> (out_r.irq_pending == (irq_r != 32'd0)))
    else $error("irq_pending disagrees with interrupt status");

  a_status_reset : assert property (@(posedge clk) disable iff (!rst_n)
    (is_write && cmd.reg_code == REG_STATUS && cmd.data == 32'd0)
      |=> (irq_r == 32'd0 && !out_r.irq_pending && !out_r.q0_ready))
    else $error("status zero did not clear ready and interrupts");

  a_event_sets_irq : assert property (@(posedge clk) disable iff (!rst_n)
    (exec && cmd.kind == OP_EVENT) |=> (irq_r[0] && out_r.irq_pending))
    else $error("completion event did not raise interrupt bit 0");

endmodule
